/* sv/ppsrt_pkg.sv */
// shared types, constants and codes for the point pair shared region test unit
`default_nettype none

package ppsrt_pkg;

    // parameter defaults
    localparam int NUM_BOXES_DEF   = 32;
    localparam int COORD_WIDTH_DEF = 24;

    // fixed field widths
    localparam int ENTRY_INDEX_W = 5;
    localparam int HIT_W         = 6;
    localparam int OUT_TDATA_W   = 32;

    localparam logic [HIT_W-1:0] HIT_NONE = {HIT_W{1'b1}};

    // opcode codes carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic start_query;
        logic write_entry;
        logic walk;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_end;
        logic out_full;
    } sts_t;

endpackage

`default_nettype wire

/* sv/point_pair_shared_region_test_unit.sv */
// top level of the point pair shared region test unit
// a write item's result goes from the done state into the output register
// a query's result follows a walk over the entries read, up to and including
//   the end mark or the last entry, then the done state and the output register
// the next item is accepted once the last result is loaded into the output register,
//   held off while an untaken result holds the output register
// reset: rst_n clears the entry valid bits at once, so the table starts empty
`default_nettype none

module point_pair_shared_region_test_unit #(
    parameter int NUM_BOXES   = ppsrt_pkg::NUM_BOXES_DEF,
    parameter int COORD_WIDTH = ppsrt_pkg::COORD_WIDTH_DEF,
    localparam int IN_BITS    = ppsrt_pkg::ENTRY_INDEX_W + 8 * COORD_WIDTH,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input item stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // from bit 0: entry_index, box_min_x, box_max_x, box_min_z, box_max_z,
    // first_point_x, first_point_z, second_point_x, second_point_z, zero pad
    input  wire logic [IN_TDATA_W-1:0]        s_tdata,
    // opcode: 0 writes a box entry, 1 queries a point pair
    input  wire logic                         s_tuser,
    // result item stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // from bit 0: shares_region, first_hit_a, later_hit_a, first_hit_b,
    // later_hit_b, zero pad
    output logic [ppsrt_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // command and status between controller and datapath
    ppsrt_pkg::cmd_t cmd;
    ppsrt_pkg::sts_t sts;

    // controller: idle, walk the table, hand the result to the output register
    ppsrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: table memory, both points tested against one entry per cycle
    ppsrt_dp #(
        .NUM_BOXES   (NUM_BOXES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* sv/ppsrt_ctrl.sv */
// controller state machine for the point pair shared region test unit
`default_nettype none

module ppsrt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tuser,
    output logic               s_tready,
    input  wire logic          m_tready,
    input  wire ppsrt_pkg::sts_t sts,
    output ppsrt_pkg::cmd_t    cmd
);

    ppsrt_pkg::state_t state_reg;
    ppsrt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppsrt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppsrt_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == ppsrt_pkg::OP_QUERY)
                    begin
                        state_next = ppsrt_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = ppsrt_pkg::S_DONE;
                    end
                end
            end
            ppsrt_pkg::S_WALK:
            begin
                if (sts.walk_end)
                begin
                    state_next = ppsrt_pkg::S_DONE;
                end
            end
            ppsrt_pkg::S_DONE:
            begin
                if (!sts.out_full || m_tready)
                begin
                    state_next = ppsrt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ppsrt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready        = 1'b0;
        cmd.start_query = 1'b0;
        cmd.write_entry = 1'b0;
        cmd.walk        = 1'b0;
        cmd.load_out    = 1'b0;
        unique case (state_reg)
            ppsrt_pkg::S_IDLE:
            begin
                s_tready        = 1'b1;
                cmd.start_query = s_tvalid && (s_tuser == ppsrt_pkg::OP_QUERY);
                cmd.write_entry = s_tvalid && (s_tuser == ppsrt_pkg::OP_WRITE);
            end
            ppsrt_pkg::S_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ppsrt_pkg::S_DONE:
            begin
                cmd.load_out = !sts.out_full || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // a write finishes at once and waits for the output register
    a_write_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == ppsrt_pkg::OP_WRITE)
        |=> state_reg == ppsrt_pkg::S_DONE)
        else $error("write item did not move to done");

    // a query starts the walk in the next cycle
    a_query_to_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_query |=> cmd.walk)
        else $error("query item did not start the walk");

    // handing over the result frees the input again
    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> state_reg == ppsrt_pkg::S_IDLE)
        else $error("no return to idle after the result was loaded");

endmodule

`default_nettype wire

/* sv/ppsrt_dp.sv */
// datapath: box table, walk counter, containment tests, hit registers, output register
`default_nettype none

module ppsrt_dp #(
    parameter int NUM_BOXES   = ppsrt_pkg::NUM_BOXES_DEF,
    parameter int COORD_WIDTH = ppsrt_pkg::COORD_WIDTH_DEF,
    localparam int IN_BITS    = ppsrt_pkg::ENTRY_INDEX_W + 8 * COORD_WIDTH,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [IN_TDATA_W-1:0]           s_tdata,
    input  wire ppsrt_pkg::cmd_t                 cmd,
    output ppsrt_pkg::sts_t                      sts,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ppsrt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int CW      = COORD_WIDTH;
    localparam int IDX_W   = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
    localparam int CNT_W   = IDX_W + 1;
    localparam int ENT_W   = 4 * CW;
    localparam int BOX_OFF = ppsrt_pkg::ENTRY_INDEX_W;
    localparam int PT_OFF  = BOX_OFF + ENT_W;
    localparam int HW      = ppsrt_pkg::HIT_W;
    localparam int HEXT    = (IDX_W > HW) ? IDX_W : HW;
    localparam int PAD_W   = ppsrt_pkg::OUT_TDATA_W - 1 - 4 * HW;

    // box table, entry layout {max_z, min_z, max_x, min_x}
    logic [ENT_W-1:0]     mem [NUM_BOXES];
    logic [NUM_BOXES-1:0] valid_reg;

    logic [ppsrt_pkg::ENTRY_INDEX_W-1:0] entry_index;
    logic                                write_ok;
    logic [IDX_W-1:0]                    waddr;

    logic [CNT_W-1:0] cnt_reg;
    logic             issue;
    logic [ENT_W-1:0] rd_data_reg;
    logic             ent_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_live_reg;

    logic signed [CW-1:0] pax_reg, paz_reg, pbx_reg, pbz_reg;
    logic signed [CW-1:0] e_min_x, e_max_x, e_min_z, e_max_z;

    logic             eval, end_mark, last_ent, in_a, in_b;

    logic             fa_found_reg, la_found_reg, fb_found_reg, lb_found_reg;
    logic [IDX_W-1:0] fa_idx_reg, la_idx_reg, fb_idx_reg, lb_idx_reg;

    logic             share;
    logic [HEXT-1:0]  fa_ext, la_ext, fb_ext, lb_ext;
    logic [HW-1:0]    fa_out, la_out, fb_out, lb_out;

    logic                              out_valid_reg;
    logic [ppsrt_pkg::OUT_TDATA_W-1:0] out_data_reg;

    assign entry_index = s_tdata[ppsrt_pkg::ENTRY_INDEX_W-1:0];
    assign write_ok    = 32'(entry_index) < 32'(NUM_BOXES);
    assign waddr       = IDX_W'(entry_index);

    // table write, slots past the table are dropped
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && write_ok)
        begin
            mem[waddr] <= s_tdata[BOX_OFF +: ENT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write_entry && write_ok)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // walk: read one entry a cycle, test it the cycle after
    assign issue = cmd.walk && (cnt_reg < CNT_W'(NUM_BOXES));

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg   <= mem[cnt_reg[IDX_W-1:0]];
            ent_valid_reg <= valid_reg[cnt_reg[IDX_W-1:0]];
            rd_idx_reg    <= cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            rd_live_reg <= 1'b0;
        end
        else if (cmd.start_query)
        begin
            cnt_reg     <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            rd_live_reg <= issue;
            if (issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            pax_reg <= s_tdata[PT_OFF +: CW];
            paz_reg <= s_tdata[PT_OFF + CW +: CW];
            pbx_reg <= s_tdata[PT_OFF + 2 * CW +: CW];
            pbz_reg <= s_tdata[PT_OFF + 3 * CW +: CW];
        end
    end

    assign e_min_x = rd_data_reg[0 +: CW];
    assign e_max_x = rd_data_reg[CW +: CW];
    assign e_min_z = rd_data_reg[2 * CW +: CW];
    assign e_max_z = rd_data_reg[3 * CW +: CW];

    assign eval     = cmd.walk && rd_live_reg;
    assign end_mark = !ent_valid_reg || (e_min_x == e_max_x);
    assign last_ent = rd_idx_reg == IDX_W'(NUM_BOXES - 1);
    assign in_a     = (e_min_x <= pax_reg) && (e_max_x >= pax_reg) &&
                      (e_min_z <= paz_reg) && (e_max_z >= paz_reg);
    assign in_b     = (e_min_x <= pbx_reg) && (e_max_x >= pbx_reg) &&
                      (e_min_z <= pbz_reg) && (e_max_z >= pbz_reg);

    assign sts.walk_end = eval && (end_mark || last_ent);
    assign sts.out_full = out_valid_reg;

    // hit tracking, found flags cleared by every new item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_found_reg <= 1'b0;
            la_found_reg <= 1'b0;
            fb_found_reg <= 1'b0;
            lb_found_reg <= 1'b0;
        end
        else if (cmd.start_query || cmd.write_entry)
        begin
            fa_found_reg <= 1'b0;
            la_found_reg <= 1'b0;
            fb_found_reg <= 1'b0;
            lb_found_reg <= 1'b0;
        end
        else if (eval && !end_mark)
        begin
            if (in_a)
            begin
                if (!fa_found_reg)
                begin
                    fa_found_reg <= 1'b1;
                end
                else
                begin
                    la_found_reg <= 1'b1;
                end
            end
            if (in_b)
            begin
                if (!fb_found_reg)
                begin
                    fb_found_reg <= 1'b1;
                end
                else
                begin
                    lb_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval && !end_mark)
        begin
            if (in_a)
            begin
                if (!fa_found_reg)
                begin
                    fa_idx_reg <= rd_idx_reg;
                end
                else
                begin
                    la_idx_reg <= rd_idx_reg;
                end
            end
            if (in_b)
            begin
                if (!fb_found_reg)
                begin
                    fb_idx_reg <= rd_idx_reg;
                end
                else
                begin
                    lb_idx_reg <= rd_idx_reg;
                end
            end
        end
    end

    // shared index test on full indexes, output indexes cut to hit width
    assign share = (fa_found_reg &&
                    ((fb_found_reg && fa_idx_reg == fb_idx_reg) ||
                     (lb_found_reg && fa_idx_reg == lb_idx_reg))) ||
                   (la_found_reg &&
                    ((fb_found_reg && la_idx_reg == fb_idx_reg) ||
                     (lb_found_reg && la_idx_reg == lb_idx_reg)));

    assign fa_ext = HEXT'(fa_idx_reg);
    assign la_ext = HEXT'(la_idx_reg);
    assign fb_ext = HEXT'(fb_idx_reg);
    assign lb_ext = HEXT'(lb_idx_reg);
    assign fa_out = fa_found_reg ? fa_ext[HW-1:0] : ppsrt_pkg::HIT_NONE;
    assign la_out = la_found_reg ? la_ext[HW-1:0] : ppsrt_pkg::HIT_NONE;
    assign fb_out = fb_found_reg ? fb_ext[HW-1:0] : ppsrt_pkg::HIT_NONE;
    assign lb_out = lb_found_reg ? lb_ext[HW-1:0] : ppsrt_pkg::HIT_NONE;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, lb_out, fb_out, la_out, fa_out, share};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten");

    // a later hit needs a first hit, at a higher index
    a_later_a: assert property (@(posedge clk) disable iff (!rst_n)
        la_found_reg |-> (fa_found_reg && la_idx_reg > fa_idx_reg))
        else $error("later hit of point one out of order");

    a_later_b: assert property (@(posedge clk) disable iff (!rst_n)
        lb_found_reg |-> (fb_found_reg && lb_idx_reg > fb_idx_reg))
        else $error("later hit of point two out of order");

endmodule

`default_nettype wire
